// ===== sv/avsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// AV sync frame decider package
// Shared widths, codes and item types for the frame decider block.
// ----------------------------------------------------------------------------
`default_nettype none

package avsfd_pkg;

	localparam int TIME_BITS    = 48;
	localparam int FRAC_BITS    = 8;
	localparam int COUNT_BITS   = 32;
	localparam int RESYNC_DROPS = 5;

	localparam int CLK_BITS   = TIME_BITS + FRAC_BITS;
	localparam int DRIFT_BITS = TIME_BITS + 1;
	localparam int RUN_BITS   = $clog2(RESYNC_DROPS + 2);
	localparam int SPEED_SHIFT = 8 - FRAC_BITS;

	localparam int DROP_THR_BITS = 25;
	localparam int DUP_THR_BITS  = 24;
	localparam int WINDOW_BITS   = 24;
	localparam int SPEED_BITS    = 16;
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 25;

	localparam int ACTION_BITS   = 3;
	localparam int DECISION_BITS = 2;
	localparam int STATE_BITS    = 2;

	localparam int IN_DATA_BITS  = ((TIME_BITS + 7) / 8) * 8;
	localparam int RES_BITS      = DECISION_BITS + TIME_BITS + 2 * DRIFT_BITS
		+ 2 * COUNT_BITS + STATE_BITS + 2;
	localparam int OUT_DATA_BITS = ((RES_BITS + 7) / 8) * 8;

	typedef logic signed [CLK_BITS-1:0]   clk_t;
	typedef logic signed [DRIFT_BITS-1:0] drift_t;
	typedef logic [COUNT_BITS-1:0]        count_t;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_TICK     = 3'd0,
		ACT_AUDIO_TS = 3'd1,
		ACT_FRAME    = 3'd2,
		ACT_SEEK     = 3'd3,
		ACT_PAUSE    = 3'd4,
		ACT_RESUME   = 3'd5,
		ACT_VIDEO_TS = 3'd6
	} action_e;

	typedef enum logic [DECISION_BITS-1:0] {
		DEC_PRESENT = 2'd0,
		DEC_WAIT    = 2'd1,
		DEC_DROP    = 2'd2
	} decision_e;

	typedef enum logic [STATE_BITS-1:0] {
		PS_IDLE      = 2'd0,
		PS_BUFFERING = 2'd1,
		PS_PLAYING   = 2'd2,
		PS_SEEKING   = 2'd3
	} play_state_e;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_DROP_THR  = 3'd0,
		REG_DUP_THR   = 3'd1,
		REG_WINDOW    = 3'd2,
		REG_MASTER    = 3'd3,
		REG_SPEED     = 3'd4
	} reg_index_e;

	localparam logic SRC_AUDIO = 1'b0;
	localparam logic SRC_VIDEO = 1'b1;

	typedef struct packed {
		logic [DROP_THR_BITS-1:0] drop_thr;
		logic [DUP_THR_BITS-1:0]  dup_thr;
		logic [WINDOW_BITS-1:0]   window;
		logic                     master;
		logic [SPEED_BITS-1:0]    speed;
	} cfg_t;

	typedef struct packed {
		action_e              action;
		logic [TIME_BITS-1:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic                  resynced;
		logic                  is_paused;
		play_state_e           play_state;
		count_t                dup_tally;
		count_t                drop_tally;
		drift_t                aud_skew;
		drift_t                vid_skew;
		logic [TIME_BITS-1:0]  clock_now;
		decision_e             decision;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/av_sync_frame_decider_top.sv =====
// ----------------------------------------------------------------------------
// AV sync frame decider
// Master playback clock with drift tracking and drop/wait/present verdicts.
//
//  Channel  Direction  Signals                        Content
//  s_*      in         s_tvalid s_tready s_tuser      action and timestamp
//                      s_tdata
//  m_*      out        m_tvalid m_tready m_tdata      verdict, clock and statistics
//  cfg_*    in         cfg_we cfg_addr cfg_wdata      register writes, no read-back
//
// Every item takes one pass through the core: it is registered on entry, the
// clock, drift and counter update is worked out from the input register and
// written to the core state as the result is registered on exit, and a new
// item can enter every cycle unless the output stalls. Reset loads the register
// defaults, stops the clock and clears all statistics. A stalled output holds
// its item and the input register stops taking items until it moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module av_sync_frame_decider_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// action
	input  wire logic [avsfd_pkg::ACTION_BITS-1:0]    s_tuser,
	// timestamp
	input  wire logic [avsfd_pkg::IN_DATA_BITS-1:0]   s_tdata,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// decision, clock_now, vid_skew, aud_skew, drop_tally,
	// dup_tally, play_state, is_paused, resynced
	output logic [avsfd_pkg::OUT_DATA_BITS-1:0]       m_tdata,
	input  wire logic                                 cfg_we,
	input  wire logic [avsfd_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  wire logic [avsfd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
	import avsfd_pkg::*;

	cfg_t     cfg;
	in_item_t item;
	result_t  result;
	logic     item_valid;
	logic     take;

	// An item moves into the core only when the output register has room.
	assign take = item_valid && (!m_tvalid || m_tready);

	avsfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	avsfd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.take     (take),
		.valid    (item_valid),
		.item     (item)
	);

	avsfd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.take   (take),
		.item   (item),
		.result (result)
	);

	avsfd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.result   (result),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// ===== sv/avsfd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// AV sync frame decider configuration registers
// Write-only register file for thresholds, master source and speed.
// ----------------------------------------------------------------------------
`default_nettype none

module avsfd_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [avsfd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  wire logic [avsfd_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	output avsfd_pkg::cfg_t                          cfg
);
	import avsfd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drop_thr <= DROP_THR_BITS'(-100000);
			cfg_q.dup_thr  <= DUP_THR_BITS'(100000);
			cfg_q.window   <= WINDOW_BITS'(40000);
			cfg_q.master   <= SRC_AUDIO;
			cfg_q.speed    <= SPEED_BITS'(256);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DROP_THR: cfg_q.drop_thr <= cfg_wdata[DROP_THR_BITS-1:0];
				REG_DUP_THR:  cfg_q.dup_thr  <= cfg_wdata[DUP_THR_BITS-1:0];
				REG_WINDOW:   cfg_q.window   <= cfg_wdata[WINDOW_BITS-1:0];
				REG_MASTER:   cfg_q.master   <= cfg_wdata[0];
				REG_SPEED:    cfg_q.speed    <= cfg_wdata[SPEED_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== sv/avsfd_in_reg.sv =====
// ----------------------------------------------------------------------------
// AV sync frame decider input register
// Holds one accepted item until the core has taken it.
// ----------------------------------------------------------------------------
`default_nettype none

module avsfd_in_reg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [avsfd_pkg::ACTION_BITS-1:0]   s_tuser,
	input  wire logic [avsfd_pkg::IN_DATA_BITS-1:0]  s_tdata,
	input  wire logic                                take,
	output logic                                     valid,
	output avsfd_pkg::in_item_t                      item
);
	import avsfd_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action    <= action_e'(s_tuser);
			item_s1.timestamp <= s_tdata[TIME_BITS-1:0];
		end
	end

	assign valid = valid_s1;
	assign item  = item_s1;

endmodule

`default_nettype wire

// ===== sv/avsfd_core.sv =====
// ----------------------------------------------------------------------------
// AV sync frame decider core
// Master clock, drift and counter state with the single-pass update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module avsfd_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire avsfd_pkg::cfg_t      cfg,
	input  wire logic                 take,
	input  wire avsfd_pkg::in_item_t  item,
	output avsfd_pkg::result_t        result
);
	import avsfd_pkg::*;

	localparam clk_t CLK_MAX = {1'b0, {(CLK_BITS-1){1'b1}}};

	clk_t                  master_clock_q, master_clock_d;
	logic                  frozen_q, frozen_d;
	play_state_e           mode_q, mode_d;
	logic [RUN_BITS-1:0]   run_q, run_d, run_inc;
	count_t                drops_q, drops_d, dups_q, dups_d;
	drift_t                vdrift_q, vdrift_d, adrift_q, adrift_d;

	clk_t                  ts_scaled;
	logic signed [TIME_BITS-1:0] ts_s, clk_int;
	drift_t                drift, drop_thr, dup_thr, window;
	logic signed [CLK_BITS:0] tick_sum;
	decision_e             decision;
	logic                  resync;

	assign ts_s      = signed'(item.timestamp);
	assign ts_scaled = clk_t'(ts_s) <<< FRAC_BITS;
	assign clk_int   = master_clock_q[CLK_BITS-1:FRAC_BITS];
	assign drift     = drift_t'(ts_s) - drift_t'(clk_int);
	assign drop_thr  = signed'({{(DRIFT_BITS-DROP_THR_BITS){cfg.drop_thr[DROP_THR_BITS-1]}},
		cfg.drop_thr});
	assign dup_thr   = signed'(DRIFT_BITS'(cfg.dup_thr));
	assign window    = signed'(DRIFT_BITS'(cfg.window));
	assign tick_sum  = (CLK_BITS+1)'(master_clock_q)
		+ signed'((CLK_BITS+1)'(cfg.speed >> SPEED_SHIFT));
	assign run_inc   = run_q + RUN_BITS'(1);

	always_comb begin
		master_clock_d = master_clock_q;
		frozen_d       = frozen_q;
		mode_d         = mode_q;
		run_d          = run_q;
		drops_d        = drops_q;
		dups_d         = dups_q;
		vdrift_d       = vdrift_q;
		adrift_d       = adrift_q;
		decision       = DEC_PRESENT;
		resync         = 1'b0;
		unique case (item.action)
			ACT_TICK: begin
				if (!frozen_q) begin
					// The increment is never negative, so only the top can be crossed.
					if (tick_sum[CLK_BITS] != tick_sum[CLK_BITS-1])
						master_clock_d = CLK_MAX;
					else
						master_clock_d = tick_sum[CLK_BITS-1:0];
				end
			end
			ACT_AUDIO_TS: begin
				if (cfg.master == SRC_AUDIO) begin
					master_clock_d = ts_scaled;
					adrift_d       = '0;
				end else begin
					adrift_d = drift;
				end
			end
			ACT_VIDEO_TS: begin
				if (cfg.master == SRC_VIDEO) begin
					master_clock_d = ts_scaled;
					vdrift_d       = '0;
				end else begin
					vdrift_d = drift;
				end
			end
			ACT_FRAME: begin
				vdrift_d = drift;
				if (drift < drop_thr) begin
					decision = DEC_DROP;
					drops_d  = (drops_q == '1) ? drops_q : drops_q + COUNT_BITS'(1);
					if (run_inc > RUN_BITS'(RESYNC_DROPS)) begin
						// Too many drops in a row: pull the clock onto this frame when video is the master.
						if (cfg.master == SRC_VIDEO) begin
							master_clock_d = ts_scaled;
							vdrift_d       = '0;
						end
						run_d  = '0;
						resync = 1'b1;
					end else begin
						run_d = run_inc;
					end
				end else if (drift > dup_thr) begin
					decision = DEC_WAIT;
					dups_d   = (dups_q == '1) ? dups_q : dups_q + COUNT_BITS'(1);
				end else begin
					run_d = '0;
					// A frame behind the clock always presents inside the thresholds.
					decision = (drift > window) ? DEC_WAIT : DEC_PRESENT;
				end
			end
			ACT_SEEK: begin
				mode_d         = PS_SEEKING;
				master_clock_d = ts_scaled;
				drops_d        = '0;
				dups_d         = '0;
				vdrift_d       = '0;
				adrift_d       = '0;
				run_d          = '0;
			end
			ACT_PAUSE: begin
				frozen_d = 1'b1;
				mode_d   = PS_IDLE;
			end
			ACT_RESUME: begin
				frozen_d = 1'b0;
				mode_d   = PS_PLAYING;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_clock_q <= '0;
			frozen_q       <= 1'b1;
			mode_q         <= PS_IDLE;
			run_q          <= '0;
			drops_q        <= '0;
			dups_q         <= '0;
			vdrift_q       <= '0;
			adrift_q       <= '0;
		end else if (take) begin
			master_clock_q <= master_clock_d;
			frozen_q       <= frozen_d;
			mode_q         <= mode_d;
			run_q          <= run_d;
			drops_q        <= drops_d;
			dups_q         <= dups_d;
			vdrift_q       <= vdrift_d;
			adrift_q       <= adrift_d;
		end
	end

	always_comb begin
		result.decision   = decision;
		result.clock_now  = master_clock_d[CLK_BITS-1:FRAC_BITS];
		result.vid_skew   = vdrift_d;
		result.aud_skew   = adrift_d;
		result.drop_tally = drops_d;
		result.dup_tally  = dups_d;
		result.play_state = mode_d;
		result.is_paused  = frozen_d;
		result.resynced   = resync;
	end

endmodule

`default_nettype wire

// ===== sv/avsfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// AV sync frame decider output register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module avsfd_out_reg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                load,
	input  wire avsfd_pkg::result_t                  result,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [avsfd_pkg::OUT_DATA_BITS-1:0]      m_tdata
);
	import avsfd_pkg::*;

	logic    valid_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_DATA_BITS'(result_q);

endmodule

`default_nettype wire

// ===== verif/av_sync_frame_decider_top_tb.sv =====
// ----------------------------------------------------------------------------
// AV sync frame decider testbench
// Drives action items into the frame decider through the input stream, keeps
// its own model of the master clock, drift registers and verdict counters,
// and compares every result item field by field with the predicted one. A
// short directed sequence is followed by random playback under several
// register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------

module av_sync_frame_decider_top_tb;

	import avsfd_pkg::*;

	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     SETTLE_CYCLES  = 6;
	localparam int     HOLD_AT        = 500;
	localparam int     HOLD_LEN       = 300;
	localparam int     QUIET_LEN      = 150;
	localparam longint CLK_LIMIT      = (longint'(1) <<< (CLK_BITS - 1)) - 1;
	localparam longint TS_MAX         = (longint'(1) <<< (TIME_BITS - 1)) - 1;
	localparam longint TS_MIN         = -TS_MAX - 1;

	// Action code with no meaning to the block; it must leave the state alone.
	localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 3'd7;

	typedef struct packed {
		logic [ACTION_BITS-1:0] action;
		logic [TIME_BITS-1:0]   timestamp;
	} sync_item_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [ACTION_BITS-1:0]   s_tuser   = '0;
	logic [IN_DATA_BITS-1:0]  s_tdata   = '0;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     cfg_we    = 1'b0;
	logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	av_sync_frame_decider_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Model of the decider state and of its registers.
	clk_t                     pc_clock;
	logic                     pc_frozen;
	play_state_e              pc_mode;
	logic [RUN_BITS-1:0]      pc_drop_run;
	count_t                   pc_drops;
	count_t                   pc_dups;
	drift_t                   pc_vdrift;
	drift_t                   pc_adrift;
	logic signed [DROP_THR_BITS-1:0] cf_drop_thr;
	logic [DUP_THR_BITS-1:0]  cf_dup_thr;
	logic [WINDOW_BITS-1:0]   cf_window;
	logic                     cf_master;
	logic [SPEED_BITS-1:0]    cf_speed;

	// Rough clock estimate used only to aim generated timestamps near the clock.
	longint                   gen_clock_q;
	logic                     gen_running;

	sync_item_t pending_items[$];
	result_t    expected_results[$];
	sync_item_t next_item;
	result_t    seen_result;
	result_t    want_result;

	int send_gap      = 0;
	int send_quiet    = 0;
	int sink_gap      = 0;
	int sink_quiet    = 0;
	int sink_hold     = 0;
	int stall_cycles  = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int mismatch_count = 0;
	int settings_used = 0;
	int present_seen  = 0;
	int wait_seen     = 0;
	int drop_seen     = 0;
	int resync_seen   = 0;

	function automatic longint clock_whole();
		return longint'(pc_clock >>> FRAC_BITS);
	endfunction

	task automatic take_report(input longint ts, input logic src);
		if (src == cf_master)
			pc_clock = clk_t'(ts <<< FRAC_BITS);
		if (src == SRC_VIDEO)
			pc_vdrift = drift_t'(ts - clock_whole());
		else
			pc_adrift = drift_t'(ts - clock_whole());
	endtask

	task automatic predict_step(input logic [ACTION_BITS-1:0] act,
			input logic [TIME_BITS-1:0] ts_bits);
		longint    ts;
		longint    drift;
		longint    inc;
		longint    mag;
		longint    now_int;
		decision_e verdict;
		logic      hit_limit;
		result_t   res;
		ts = longint'($signed(ts_bits));
		verdict = DEC_PRESENT;
		hit_limit = 1'b0;
		case (act)
			ACT_TICK: begin
				if (!pc_frozen) begin
					inc = longint'(cf_speed >> SPEED_SHIFT);
					if (longint'(pc_clock) > CLK_LIMIT - inc)
						pc_clock = clk_t'(CLK_LIMIT);
					else
						pc_clock = clk_t'(longint'(pc_clock) + inc);
				end
			end
			ACT_AUDIO_TS: take_report(ts, SRC_AUDIO);
			ACT_VIDEO_TS: take_report(ts, SRC_VIDEO);
			ACT_FRAME: begin
				drift = ts - clock_whole();
				pc_vdrift = drift_t'(drift);
				if (drift < longint'(cf_drop_thr)) begin
					if (pc_drops != '1)
						pc_drops = pc_drops + 1;
					pc_drop_run = pc_drop_run + 1;
					// Too many drops in a row: pull the clock back onto the video when video is the master.
					if (pc_drop_run > RESYNC_DROPS) begin
						take_report(ts, SRC_VIDEO);
						pc_drop_run = '0;
						hit_limit = 1'b1;
					end
					verdict = DEC_DROP;
				end else if (drift > longint'(cf_dup_thr)) begin
					if (pc_dups != '1)
						pc_dups = pc_dups + 1;
					verdict = DEC_WAIT;
				end else begin
					// Early frames outside the window wait, but are not counted.
					mag = (drift < 0) ? -drift : drift;
					pc_drop_run = '0;
					if (mag <= longint'(cf_window) || drift < 0)
						verdict = DEC_PRESENT;
					else
						verdict = DEC_WAIT;
				end
			end
			ACT_SEEK: begin
				pc_mode = PS_SEEKING;
				pc_clock = clk_t'(ts <<< FRAC_BITS);
				pc_drops = '0;
				pc_dups = '0;
				pc_vdrift = '0;
				pc_adrift = '0;
				pc_drop_run = '0;
			end
			ACT_PAUSE: begin
				pc_frozen = 1'b1;
				pc_mode = PS_IDLE;
			end
			ACT_RESUME: begin
				pc_frozen = 1'b0;
				pc_mode = PS_PLAYING;
			end
			default: ;
		endcase
		now_int = clock_whole();
		res.decision = verdict;
		res.clock_now = now_int[TIME_BITS-1:0];
		res.vid_skew = pc_vdrift;
		res.aud_skew = pc_adrift;
		res.drop_tally = pc_drops;
		res.dup_tally = pc_dups;
		res.play_state = pc_mode;
		res.is_paused = pc_frozen;
		res.resynced = hit_limit;
		expected_results.push_back(res);
	endtask

	task automatic check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return 0;
		if (roll < 96)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic longint random_time();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return longint'($signed(bits[TIME_BITS-1:0]));
	endfunction

	function automatic longint jitter(input int unsigned span);
		return longint'($urandom_range(0, 2 * span)) - longint'(span);
	endfunction

	// Offsets from the clock: most land on or beside a verdict boundary, the rest are spread wide.
	function automatic longint frame_offset();
		case ($urandom_range(0, 5))
			0: return longint'(cf_drop_thr) + jitter(2);
			1: return longint'(cf_dup_thr) + jitter(2);
			2: return longint'(cf_window) + jitter(2);
			3: return -longint'(cf_window) + jitter(2);
			4: return jitter(250000);
			default: return random_time();
		endcase
	endfunction

	task automatic queue_item(input logic [ACTION_BITS-1:0] act, input longint ts);
		sync_item_t item;
		item.action = act;
		item.timestamp = ts[TIME_BITS-1:0];
		pending_items.push_back(item);
		case (act)
			ACT_TICK: if (gen_running) gen_clock_q += longint'(cf_speed);
			ACT_AUDIO_TS: if (cf_master == SRC_AUDIO) gen_clock_q = ts <<< FRAC_BITS;
			ACT_VIDEO_TS: if (cf_master == SRC_VIDEO) gen_clock_q = ts <<< FRAC_BITS;
			ACT_SEEK: gen_clock_q = ts <<< FRAC_BITS;
			ACT_PAUSE: gen_running = 1'b0;
			ACT_RESUME: gen_running = 1'b1;
			default: ;
		endcase
	endtask

	task automatic queue_random_items(input int count);
		int     roll;
		longint base;
		for (int n = 0; n < count; n++) begin
			base = gen_clock_q >>> FRAC_BITS;
			roll = $urandom_range(0, 99);
			if (roll < 8)
				queue_item(3'($urandom_range(0, 7)), random_time());
			else if (roll < 46)
				queue_item(ACT_TICK, random_time());
			else if (roll < 74) begin
				// Now and then a run of late frames long enough to force a resync.
				if ($urandom_range(0, 19) == 0)
					repeat ($urandom_range(6, 8))
						queue_item(ACT_FRAME, base + longint'(cf_drop_thr) - 1
							- longint'($urandom_range(0, 5000)));
				else
					queue_item(ACT_FRAME, base + frame_offset());
			end else if (roll < 82)
				queue_item(ACT_AUDIO_TS, base + jitter(150000));
			else if (roll < 90)
				queue_item(ACT_VIDEO_TS, base + jitter(150000));
			else if (roll < 93)
				queue_item(ACT_SEEK,
					($urandom_range(0, 3) == 0) ? random_time() : jitter(2000000));
			else if (roll < 96)
				queue_item(ACT_PAUSE, random_time());
			else
				queue_item(ACT_RESUME, random_time());
		end
	endtask

	// Sampled on the falling edge, after every rising-edge update has settled.
	task automatic wait_idle();
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input reg_index_e idx, input longint value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value[CFG_DATA_BITS-1:0];
		case (idx)
			REG_DROP_THR: cf_drop_thr = value[DROP_THR_BITS-1:0];
			REG_DUP_THR:  cf_dup_thr = value[DUP_THR_BITS-1:0];
			REG_WINDOW:   cf_window = value[WINDOW_BITS-1:0];
			REG_MASTER:   cf_master = value[0];
			REG_SPEED:    cf_speed = value[SPEED_BITS-1:0];
			default: ;
		endcase
	endtask

	// Registers change only once every outstanding result has come back.
	task automatic start_phase(input longint drop_thr, input longint dup_thr,
			input longint window, input logic master, input longint speed);
		wait_idle();
		write_register(REG_DROP_THR, drop_thr);
		write_register(REG_DUP_THR, dup_thr);
		write_register(REG_WINDOW, window);
		write_register(REG_MASTER, longint'(master));
		write_register(REG_SPEED, speed);
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_clock_q = longint'(pc_clock);
		gen_running = !pc_frozen;
		settings_used++;
		queue_item(ACT_RESUME, random_time());
	endtask

	// Input driver: takes items from the pending queue, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser <= '0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_step(s_tuser, s_tdata[TIME_BITS-1:0]);
				items_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					next_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= next_item.action;
					s_tdata <= next_item.timestamp;
					if (send_quiet > 0)
						send_quiet--;
					else if ($urandom_range(0, 199) == 0)
						send_quiet = QUIET_LEN;
					send_gap = (send_quiet > 0) ? 0 : idle_length();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each result item and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_result = result_t'(m_tdata[RES_BITS-1:0]);
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result item arrived with nothing predicted");
					mismatch_count++;
				end else begin
					want_result = expected_results.pop_front();
					check_field("decision", want_result.decision, seen_result.decision);
					check_field("clock_now", $signed(want_result.clock_now),
						$signed(seen_result.clock_now));
					check_field("vid_skew", want_result.vid_skew,
						seen_result.vid_skew);
					check_field("aud_skew", want_result.aud_skew,
						seen_result.aud_skew);
					check_field("drop_tally", want_result.drop_tally,
						seen_result.drop_tally);
					check_field("dup_tally", want_result.dup_tally,
						seen_result.dup_tally);
					check_field("play_state", want_result.play_state,
						seen_result.play_state);
					check_field("is_paused", want_result.is_paused, seen_result.is_paused);
					check_field("resynced", want_result.resynced, seen_result.resynced);
				end
				if (seen_result.decision == DEC_PRESENT)
					present_seen++;
				else if (seen_result.decision == DEC_WAIT)
					wait_seen++;
				else if (seen_result.decision == DEC_DROP)
					drop_seen++;
				if (seen_result.resynced)
					resync_seen++;
				// One long hold-off so that the block backs up onto its input.
				if (results_seen == HOLD_AT)
					sink_hold = HOLD_LEN;
			end
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (sink_quiet > 0)
					sink_quiet--;
				else if ($urandom_range(0, 199) == 0)
					sink_quiet = QUIET_LEN;
				sink_gap = (sink_quiet > 0) ? 0 : idle_length();
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		pc_clock = '0;
		pc_frozen = 1'b1;
		pc_mode = PS_IDLE;
		pc_drop_run = '0;
		pc_drops = '0;
		pc_dups = '0;
		pc_vdrift = '0;
		pc_adrift = '0;
		cf_drop_thr = -25'sd100000;
		cf_dup_thr = 24'd100000;
		cf_window = 24'd40000;
		cf_master = SRC_AUDIO;
		cf_speed = 16'd256;
		gen_clock_q = 0;
		gen_running = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, run on the register values left by reset.
		queue_item(ACT_TICK, 0);
		queue_item(ACT_UNUSED, TS_MAX);
		queue_item(ACT_VIDEO_TS, 5000);
		queue_item(ACT_RESUME, 0);
		queue_item(ACT_TICK, 0);
		queue_item(ACT_PAUSE, 0);
		queue_item(ACT_TICK, 0);
		queue_item(ACT_RESUME, 0);
		queue_item(ACT_AUDIO_TS, 1000);
		queue_item(ACT_FRAME, 1000);
		queue_item(ACT_FRAME, 51000);
		queue_item(ACT_FRAME, 201000);
		queue_item(ACT_FRAME, -59000);
		queue_item(ACT_FRAME, TS_MIN);
		queue_item(ACT_FRAME, TS_MAX);
		repeat (5) queue_item(ACT_FRAME, -199000);
		queue_item(ACT_FRAME, 101000);
		queue_item(ACT_FRAME, -99000);
		queue_item(ACT_SEEK, TS_MAX);
		queue_item(ACT_TICK, 0);
		queue_item(ACT_SEEK, TS_MIN);
		queue_item(ACT_PAUSE, -1);

		start_phase(-100000, 100000, 40000, SRC_AUDIO, 256);
		queue_random_items(300);
		start_phase(-16777215, 0, 0, SRC_VIDEO, 65535);
		queue_random_items(300);
		start_phase(0, 16777215, 16777215, SRC_AUDIO, 0);
		queue_random_items(300);
		start_phase(-longint'($urandom_range(0, 300000)), $urandom_range(0, 300000),
			$urandom_range(0, 300000), 1'($urandom_range(0, 1)), $urandom_range(0, 65535));
		queue_random_items(300);
		start_phase(-longint'($urandom_range(0, 16777215)), $urandom_range(0, 16777215),
			$urandom_range(0, 16777215), 1'($urandom_range(0, 1)), $urandom_range(0, 65535));
		queue_random_items(300);
		start_phase(-100000, 100000, 40000, SRC_VIDEO, 128);
		queue_random_items(300);

		wait_idle();
		$display("Covered %0d items and %0d results over %0d register settings.",
			items_sent, results_seen, settings_used);
		$display("Verdicts seen: %0d present, %0d wait, %0d drop, %0d resyncs.",
			present_seen, wait_seen, drop_seen, resync_seen);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
